### src/moving_average_threshold_alert_defines.svh
// Assertion macros used by the checker file
`ifndef MOVING_AVERAGE_THRESHOLD_ALERT_DEFINES_SVH
`define MOVING_AVERAGE_THRESHOLD_ALERT_DEFINES_SVH

// Clocked assertion, held off while reset is low
`define MATA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset
`define MATA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### src/mavg_pkg.sv
`timescale 1ns / 1ps

package mavg_pkg;

    // Ring depth; must be a power of two (mean is taken by shifting)
    localparam int RING_DEPTH      = 16;
    localparam int SAMPLE_W        = 12;
    localparam int SLOT_W          = $clog2(RING_DEPTH);
    localparam int SUM_W           = SAMPLE_W + SLOT_W;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 16;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 12'd4095;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd3000;

    // One filter result
    typedef struct packed {
        logic                alert;
        logic [SAMPLE_W-1:0] filtered;
    } t_filt_res;

endpackage

### src/mavg_ring_filter.sv
`timescale 1ns / 1ps

module mavg_ring_filter
    import mavg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_threshold,
    output t_filt_res           o_res
);

    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [SLOT_W-1:0]   r_slot;
    logic [SUM_W-1:0]    r_sum;
    logic                r_alert;

    logic [SLOT_W-1:0]   n_slot;
    logic [SUM_W-1:0]    n_sum;
    logic                n_alert;
    logic                slot_last;
    logic [SUM_W-1:0]    sum_rnd;
    logic [SUM_W-1:0]    mean_full;
    logic [SAMPLE_W-1:0] mean;

    // Replace the oldest sample in the running sum
    always_comb begin
        n_sum     = r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(i_sample);
        slot_last = (r_slot == SLOT_W'(RING_DEPTH - 1));
        n_slot    = slot_last ? '0 : r_slot + 1'b1;
    end

    // Round, scale and clamp the mean
    always_comb begin
        sum_rnd   = n_sum + SUM_W'(RING_DEPTH / 2);
        mean_full = sum_rnd >> SLOT_W;
        if (mean_full > SUM_W'(SAMPLE_MAX)) begin
            mean = SAMPLE_MAX;
        end else begin
            mean = mean_full[SAMPLE_W-1:0];
        end
    end

    // Clear the flag on wrap, then raise it if the mean is above threshold
    always_comb begin
        n_alert = (r_alert && !slot_last) || (mean > i_threshold);
    end

    assign o_res.filtered = mean;
    assign o_res.alert    = n_alert;

    // Commit ring, sum, slot and flag once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_slot  <= '0;
            r_sum   <= '0;
            r_alert <= 1'b0;
        end else if (i_step) begin
            r_ring[r_slot] <= i_sample;
            r_slot         <= n_slot;
            r_sum          <= n_sum;
            r_alert        <= n_alert;
        end
    end

endmodule

### src/moving_average_threshold_alert.sv
`timescale 1ns / 1ps
//  Channel      Dir  Signals                                    Payload
//  input        in   i_s_axis_tvalid/o_s_axis_tready/_tdata     sample
//  result       out  o_m_axis_tvalid/i_m_axis_tready/_tdata     filtered, alert
//  threshold    in   i_cfg_valid/o_cfg_ready/i_cfg_data         alert_threshold
//
//  One transaction per cycle sustained while the result is not stalled; a
//  sample passes the input register, then the result register, with the
//  ring, sum and flag update in between. The input register takes a new
//  sample whenever it is empty or the result register is empty or being
//  drained; a stalled result holds both stages in place. Synchronous active-low
//  reset clears the 16-entry ring, sum, slot, flag, both valid bits and loads
//  the threshold with 3000. The threshold port is always ready.

module moving_average_threshold_alert
    import mavg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [11:0] sample
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // [11:0] filtered, [12] alert
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_filt_res           r_out;
    logic [SAMPLE_W-1:0] r_threshold;

    logic                advance;
    logic                step;
    t_filt_res           res;

    // Move the pipeline when the result register can take a new value
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;

    mavg_ring_filter u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_sample    (r_in_sample),
        .i_threshold (r_threshold),
        .o_res       (res)
    );

    // Capture input samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_sample <= i_s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out.alert, r_out.filtered});

endmodule

### src/mavg_checker.sv
`timescale 1ns / 1ps
`include "moving_average_threshold_alert_defines.svh"

module mavg_checker
    import mavg_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result stays offered
    `MATA_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid, "result dropped while stalled")

    // A stalled result keeps its payload
    `MATA_ASSERT(a_out_stable, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata), "result changed while stalled")

    // No result is offered right after reset
    `MATA_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !o_m_axis_tvalid, "result valid after reset")

    // Padding bits above the alert flag stay zero
    `MATA_ASSERT(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[M_TDATA_W-1:SAMPLE_W+1] == '0), "nonzero padding in result")

    // An accepted sample is followed by an offered result once it has passed the input and result registers
    `MATA_ASSERT(a_in_to_out, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> ##1 o_m_axis_tvalid, "accepted sample gave no result")

endmodule

bind moving_average_threshold_alert mavg_checker u_mavg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
